### hw/rtl/oaht_pkg.sv
`default_nettype none

package oaht_pkg;

    localparam int KEY_W   = 32;
    localparam int SLOT_W  = 10;
    localparam int STATE_W = 2;
    localparam int ENTRY_W = KEY_W + STATE_W;

    // Operation codes carried by an input beat.
    localparam logic [1:0] OP_SEARCH = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;
    // The one code with no operation; it changes nothing and answers not found.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Per-slot status kept next to the key in each table entry.
    localparam logic [STATE_W-1:0] ST_EMPTY   = 2'd0;
    localparam logic [STATE_W-1:0] ST_USED    = 2'd1;
    localparam logic [STATE_W-1:0] ST_DELETED = 2'd2;

    // Result status codes.
    localparam logic [1:0] RES_OK        = 2'd0;
    localparam logic [1:0] RES_NOT_FOUND = 2'd1;
    localparam logic [1:0] RES_PRESENT   = 2'd2;
    localparam logic [1:0] RES_EXHAUSTED = 2'd3;

    typedef struct packed {
        logic [1:0]       op;
        logic [KEY_W-1:0] key;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
    } out_beat_t;

    // Commands from the sequencer to the probe address unit.
    typedef struct packed {
        logic load;
        logic step;
    } probe_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/oaht_ram.sv
`default_nettype none

module oaht_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

### hw/rtl/oaht_probe.sv
`default_nettype none

module oaht_probe #(
    parameter int TABLE_SLOTS = 1024
) (
    input  wire logic                           aclk,
    input  wire oaht_pkg::probe_ctrl_t          ctrl,
    input  wire logic [$clog2(TABLE_SLOTS)-1:0] home,
    output logic      [$clog2(TABLE_SLOTS)-1:0] addr,
    output logic                                last
);

    import oaht_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam logic [IDX_W:0] LAST_I = (IDX_W+1)'(TABLE_SLOTS);

    logic [IDX_W:0]   i_reg,    i_next;
    logic [IDX_W-1:0] addr_reg, addr_next;

    // Triangular offsets grow by i+1 from one probe to the next, so one adder
    // walks the whole sequence; the wrap is the natural carry-out of the index.
    always_comb begin
        i_next    = i_reg;
        addr_next = addr_reg;
        if (ctrl.load) begin
            i_next    = '0;
            addr_next = home;
        end else if (ctrl.step) begin
            i_next    = i_reg + 1'b1;
            addr_next = addr_reg + IDX_W'(i_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        i_reg    <= i_next;
        addr_reg <= addr_next;
    end

    assign addr = addr_reg;
    assign last = (i_reg == LAST_I);

endmodule

`default_nettype wire

### hw/rtl/open_addressing_hash_table_unit.sv
`default_nettype none

// Open-addressing hash table of TABLE_SLOTS entries with triangular probing.
// Each input beat (search, insert or delete on a 32-bit key) gives one result
// beat. The table sits in one single-port RAM with a registered read, so every
// probe has a read state and a check state: address out, then compare the entry.
// A search or delete ends after p probes; an insert that does not find its key
// adds a second walk of q probes from the home slot to find the free slot, and
// ends after the first walk when the key is already present. An unused op code
// goes straight to the result. After reset the block clears every slot to empty,
// one per cycle, and accepts nothing until the clearing pass is done.
// A finished result waits in the output register while the block goes idle.

module open_addressing_hash_table_unit #(
    parameter int TABLE_SLOTS = 1024
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire oaht_pkg::in_beat_t  s_payload,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output oaht_pkg::out_beat_t      m_payload
);

    import oaht_pkg::*;

    localparam int IDX_W = $clog2(TABLE_SLOTS);

    typedef enum logic [6:0] {
        S_CLEAR    = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_FIND_RD  = 7'b0000100,
        S_FIND_CHK = 7'b0001000,
        S_INS_RD   = 7'b0010000,
        S_INS_CHK  = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    state_t            state_reg,  state_next;
    logic [IDX_W-1:0]  clr_reg,    clr_next;
    logic [1:0]        op_reg,     op_next;
    logic [KEY_W-1:0]  key_reg,    key_next;
    out_beat_t         res_reg,    res_next;
    logic              m_valid_reg, m_valid_next;
    out_beat_t         m_payload_reg, m_payload_next;

    probe_ctrl_t       probe_ctrl;
    logic [IDX_W-1:0]  probe_home;
    logic [IDX_W-1:0]  probe_addr;
    logic              probe_last;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_addr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    logic [STATE_W-1:0] ent_state;
    logic [KEY_W-1:0]   ent_key;
    logic               key_hit;
    logic [SLOT_W-1:0]  hit_slot;

    oaht_probe #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_probe (
        .aclk (aclk),
        .ctrl (probe_ctrl),
        .home (probe_home),
        .addr (probe_addr),
        .last (probe_last)
    );

    oaht_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign ent_state  = ram_rdata[KEY_W +: STATE_W];
    assign ent_key    = ram_rdata[KEY_W-1:0];
    assign key_hit    = (ent_state == ST_USED) && (ent_key == key_reg);
    assign hit_slot   = SLOT_W'(probe_addr);
    assign probe_home = (state_reg == S_IDLE) ? s_payload.key[IDX_W-1:0]
                                              : key_reg[IDX_W-1:0];
    assign ram_addr   = (state_reg == S_CLEAR) ? clr_reg : probe_addr;

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_payload_next = m_payload_reg;
        probe_ctrl     = '0;
        ram_we         = 1'b0;
        ram_wdata      = {ST_EMPTY, key_reg};

        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == '1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    op_next         = s_payload.op;
                    key_next        = s_payload.key;
                    probe_ctrl.load = 1'b1;
                    if (s_payload.op == OP_SEARCH || s_payload.op == OP_INSERT ||
                        s_payload.op == OP_DELETE) begin
                        state_next = S_FIND_RD;
                    end else begin
                        res_next   = '{status: RES_NOT_FOUND, slot: '0};
                        state_next = S_DONE;
                    end
                end
            end
            S_FIND_RD: begin
                state_next = S_FIND_CHK;
            end
            S_FIND_CHK: begin
                if (key_hit) begin
                    state_next = S_DONE;
                    if (op_reg == OP_INSERT) begin
                        res_next = '{status: RES_PRESENT, slot: '0};
                    end else begin
                        res_next = '{status: RES_OK, slot: hit_slot};
                        if (op_reg == OP_DELETE) begin
                            ram_we    = 1'b1;
                            ram_wdata = {ST_DELETED, key_reg};
                        end
                    end
                end else if (ent_state == ST_EMPTY || probe_last) begin
                    if (op_reg == OP_INSERT) begin
                        // Not present: walk again from the home slot for a free entry.
                        probe_ctrl.load = 1'b1;
                        state_next      = S_INS_RD;
                    end else begin
                        res_next.status = (ent_state == ST_EMPTY) ? RES_NOT_FOUND
                                                                  : RES_EXHAUSTED;
                        res_next.slot   = '0;
                        state_next      = S_DONE;
                    end
                end else begin
                    probe_ctrl.step = 1'b1;
                    state_next      = S_FIND_RD;
                end
            end
            S_INS_RD: begin
                state_next = S_INS_CHK;
            end
            S_INS_CHK: begin
                if (ent_state != ST_USED) begin
                    ram_we     = 1'b1;
                    ram_wdata  = {ST_USED, key_reg};
                    res_next   = '{status: RES_OK, slot: hit_slot};
                    state_next = S_DONE;
                end else if (probe_last) begin
                    res_next   = '{status: RES_EXHAUSTED, slot: '0};
                    state_next = S_DONE;
                end else begin
                    probe_ctrl.step = 1'b1;
                    state_next      = S_INS_RD;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_payload_next = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        res_reg       <= res_next;
        m_payload_reg <= m_payload_next;
    end

endmodule

`default_nettype wire

### hw/rtl/oaht_checker.sv
`default_nettype none

module oaht_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire oaht_pkg::in_beat_t  s_payload,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire oaht_pkg::out_beat_t m_payload
);

    import oaht_pkg::*;

    // A result beat that is not taken holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result beat changed while stalled");

    // Failed operations report slot zero.
    a_fail_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.status != RES_OK |-> m_payload.slot == '0)
        else $error("nonzero slot on a failed operation");

    // The block works on one item at a time.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is in progress");

    // Reset empties the output and starts the clearing pass.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("block not quiet after reset");

    // An item with the reserved op code answers only after the decode cycle.
    a_rsvd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_payload.op == OP_UNUSED |=> !s_ready)
        else $error("reserved op code finished too early");

endmodule

bind open_addressing_hash_table_unit oaht_checker u_oaht_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);

`default_nettype wire
